// File: rtl/disk_seek_scheduler_defines.svh
// assertion macros for the disk seek scheduler
// depends on nothing; included by the modules that carry assertions
`ifndef DISK_SEEK_SCHEDULER_DEFINES_SVH
`define DISK_SEEK_SCHEDULER_DEFINES_SVH

`ifndef ASSERT_OFF
// checked while reset is released
`define DSS_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("dss assertion failed");
// checked on every edge, reset included
`define DSS_ASSERT_NR(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("dss assertion failed");
`else
`define DSS_ASSERT(name, clk, rst_n, prop)
`define DSS_ASSERT_NR(name, clk, prop)
`endif

`endif

// File: rtl/dss_pkg.sv
// types and constants shared by the disk seek scheduler modules
// no dependencies
package dss_pkg;

  localparam int CYL_W            = 12;
  localparam int TOTAL_W          = 17;
  localparam int MAX_REQUESTS_DEF = 32;
  localparam int IDX_W_MAX        = 6;   // covers up to 64 stored requests
  localparam int CNT_W_MAX        = 7;
  localparam int FIFO_DEPTH       = 2;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] REG_POLICY     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_HEAD = 1'd1;

  localparam logic POLICY_FCFS = 1'b0;
  localparam logic POLICY_SSTF = 1'b1;

  typedef struct packed {
    logic [CYL_W-1:0] cylinder;
    logic             is_last;
  } in_item_t;

  typedef struct packed {
    logic [CYL_W-1:0]   served_cylinder;
    logic [CYL_W-1:0]   move_distance;
    logic [TOTAL_W-1:0] total_seek;
    logic               last_of_run;
    logic               dropped;
  } out_item_t;

  // one scheduled batch handed from front to back
  typedef struct packed {
    logic [CNT_W_MAX-1:0] count;
    logic                 overflow;
  } job_t;

  // request store write port
  typedef struct packed {
    logic                 en;
    logic [IDX_W_MAX-1:0] addr;
    logic [CYL_W-1:0]     data;
  } store_wr_t;

endpackage

// File: rtl/dss_front.sv
// front end: accepts requests, fills the request store, closes batches
// depends on dss_pkg
module dss_front #(
  parameter int MAX_REQUESTS = dss_pkg::MAX_REQUESTS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  dss_pkg::in_item_t  in_item_i,
  output logic               job_valid_o,
  input  logic               job_ready_i,
  output dss_pkg::job_t      job_o,
  output dss_pkg::store_wr_t wr_o,
  input  logic               done_i
);
  import dss_pkg::*;

  localparam int IDX_W = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
  localparam int CNT_W = $clog2(MAX_REQUESTS + 1);

  logic [CNT_W-1:0] count_q, count_d;
  logic             ovf_q, ovf_d;
  logic             busy_q;
  logic             accept, has_room;

  assign in_ready_o = !busy_q && job_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign has_room   = count_q < CNT_W'(MAX_REQUESTS);
  assign count_d    = has_room ? count_q + CNT_W'(1) : count_q;
  assign ovf_d      = ovf_q | !has_room;

  assign wr_o.en   = accept && has_room;
  assign wr_o.addr = IDX_W_MAX'(count_q[IDX_W-1:0]);
  assign wr_o.data = in_item_i.cylinder;

  assign job_valid_o    = accept && in_item_i.is_last;
  assign job_o.count    = CNT_W_MAX'(count_d);
  assign job_o.overflow = ovf_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
      busy_q  <= 1'b0;
    end else begin
      if (done_i) begin
        busy_q <= 1'b0;
      end
      if (accept) begin
        if (in_item_i.is_last) begin
          count_q <= '0;
          ovf_q   <= 1'b0;
          busy_q  <= 1'b1;
        end else begin
          count_q <= count_d;
          ovf_q   <= ovf_d;
        end
      end
    end
  end

endmodule

// File: rtl/dss_job_fifo.sv
// short queue of closed batches between front and back
// depends on dss_pkg
module dss_job_fifo #(
  parameter int Depth = dss_pkg::FIFO_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  dss_pkg::job_t push_data_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output dss_pkg::job_t pop_data_o
);
  import dss_pkg::*;

  localparam int PTR_W = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CNT_W = $clog2(Depth + 1);

  job_t             slot_q [Depth];
  logic [PTR_W-1:0] wptr_q, rptr_q;
  logic [CNT_W-1:0] fill_q;
  logic             push, pop;

  assign push_ready_o = fill_q != CNT_W'(Depth);
  assign pop_valid_o  = fill_q != '0;
  assign pop_data_o   = slot_q[rptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      fill_q <= '0;
    end else begin
      if (push) begin
        wptr_q <= (wptr_q == PTR_W'(Depth - 1)) ? '0 : wptr_q + PTR_W'(1);
      end
      if (pop) begin
        rptr_q <= (rptr_q == PTR_W'(Depth - 1)) ? '0 : rptr_q + PTR_W'(1);
      end
      if (push && !pop) begin
        fill_q <= fill_q + CNT_W'(1);
      end else if (pop && !push) begin
        fill_q <= fill_q - CNT_W'(1);
      end
    end
  end

endmodule

// File: rtl/dss_back.sv
// back end: request store, nearest-request (or in-order fcfs) scan and result register
// depends on dss_pkg and disk_seek_scheduler_defines.svh
`include "disk_seek_scheduler_defines.svh"
module dss_back #(
  parameter int MAX_REQUESTS = dss_pkg::MAX_REQUESTS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  dss_pkg::store_wr_t        wr_i,
  input  logic                      job_valid_i,
  output logic                      job_ready_o,
  input  dss_pkg::job_t             job_i,
  input  logic                      policy_i,
  input  logic [dss_pkg::CYL_W-1:0] start_head_i,
  output logic                      done_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output dss_pkg::out_item_t        out_item_o
);
  import dss_pkg::*;

  localparam int IDX_W = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
  localparam int CNT_W = $clog2(MAX_REQUESTS + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_EMIT
  } state_e;

  state_e              state_q;
  logic [CYL_W-1:0]    mem_q [MAX_REQUESTS];
  logic [CYL_W-1:0]    rdata_q;
  logic [CNT_W-1:0]    n_q, k_q, n_last;
  logic [IDX_W-1:0]    scan_q, pidx_q, best_idx_q;
  logic                pend_q, found_q, ovf_q;
  logic [CYL_W-1:0]    head_q, best_c_q, best_d_q, cand_d;
  logic [TOTAL_W-1:0]  sum_q, sum_sat;
  logic [TOTAL_W:0]    sum_wide;
  logic [MAX_REQUESTS-1:0] served_q;
  logic                out_valid_q;
  out_item_t           out_q;
  logic                cand_ok, better, scan_end, emit, k_last;

  // request store: one write port from the front, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr[IDX_W-1:0]] <= wr_i.data;
    end
    rdata_q <= mem_q[scan_q];
  end

  assign n_last   = n_q - CNT_W'(1);
  assign k_last   = k_q == n_last;
  assign scan_end = (policy_i == POLICY_SSTF) ? (scan_q == n_last[IDX_W-1:0]) : 1'b1;

  // compare stage on the entry read in the previous cycle
  assign cand_d  = (rdata_q >= head_q) ? rdata_q - head_q : head_q - rdata_q;
  assign cand_ok = pend_q && ((policy_i == POLICY_FCFS) || !served_q[pidx_q]);
  assign better  = !found_q || (cand_d < best_d_q) ||
                   ((cand_d == best_d_q) && (rdata_q > best_c_q));

  assign sum_wide = {1'b0, sum_q} + (TOTAL_W + 1)'(best_d_q);
  assign sum_sat  = sum_wide[TOTAL_W] ? {TOTAL_W{1'b1}} : sum_wide[TOTAL_W-1:0];

  assign emit        = (state_q == S_EMIT) && (!out_valid_q || out_ready_i);
  assign done_o      = emit && k_last;
  assign job_ready_o = state_q == S_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      n_q         <= '0;
      k_q         <= '0;
      scan_q      <= '0;
      pidx_q      <= '0;
      pend_q      <= 1'b0;
      found_q     <= 1'b0;
      ovf_q       <= 1'b0;
      head_q      <= '0;
      sum_q       <= '0;
      served_q    <= '0;
      best_idx_q  <= '0;
      best_c_q    <= '0;
      best_d_q    <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (out_ready_i && !emit) begin
        out_valid_q <= 1'b0;
      end
      if (cand_ok && better) begin
        found_q    <= 1'b1;
        best_idx_q <= pidx_q;
        best_c_q   <= rdata_q;
        best_d_q   <= cand_d;
      end
      unique case (state_q)
        S_IDLE: begin
          if (job_valid_i) begin
            n_q      <= job_i.count[CNT_W-1:0];
            ovf_q    <= job_i.overflow;
            head_q   <= start_head_i;
            sum_q    <= '0;
            served_q <= '0;
            k_q      <= '0;
            scan_q   <= '0;
            found_q  <= 1'b0;
            state_q  <= S_SCAN;
          end
        end
        S_SCAN: begin
          pend_q <= 1'b1;
          pidx_q <= scan_q;
          if (scan_end) begin
            state_q <= S_DRAIN;
          end else begin
            scan_q <= scan_q + IDX_W'(1);
          end
        end
        S_DRAIN: begin
          pend_q  <= 1'b0;
          state_q <= S_EMIT;
        end
        S_EMIT: begin
          if (emit) begin
            out_valid_q           <= 1'b1;
            out_q.served_cylinder <= best_c_q;
            out_q.move_distance   <= best_d_q;
            out_q.total_seek      <= sum_sat;
            out_q.last_of_run     <= k_last;
            out_q.dropped         <= ovf_q;
            head_q                <= best_c_q;
            sum_q                 <= sum_sat;
            served_q[best_idx_q]  <= 1'b1;
            if (k_last) begin
              state_q <= S_IDLE;
            end else begin
              k_q     <= k_q + CNT_W'(1);
              found_q <= 1'b0;
              scan_q  <= (policy_i == POLICY_SSTF) ? '0 : IDX_W'(k_q + CNT_W'(1));
              state_q <= S_SCAN;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // a result always has a chosen candidate behind it
  `DSS_ASSERT(a_emit_found, clk_i, rst_ni, (state_q == S_EMIT) |-> found_q)
  // the result counter never passes the batch size while a batch runs
  `DSS_ASSERT(a_k_in_batch, clk_i, rst_ni, (state_q != S_IDLE) |-> (k_q < n_q))
  // the final result of a batch frees the back end
  `DSS_ASSERT(a_last_idle, clk_i, rst_ni, (emit && k_last) |=> (state_q == S_IDLE))
  // no result is shown while reset is held
  `DSS_ASSERT_NR(a_rst_quiet, clk_i, !rst_ni |-> !out_valid_o)

endmodule

// File: rtl/disk_seek_scheduler.sv
// disk seek scheduler: batch fcfs / shortest-seek-first service order
// input requests are taken one per cycle while a batch fills and the job
// queue has room; after the last one each result reads every stored entry
// in shortest-seek mode, or only the next one in first-come mode
// new requests wait until the final result of the running batch is issued
// reset is asynchronous and active low; the request store is not cleared
module disk_seek_scheduler #(
  parameter int MAX_REQUESTS = dss_pkg::MAX_REQUESTS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // request channel
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  dss_pkg::in_item_t              in_item_i,
  // result channel
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output dss_pkg::out_item_t             out_item_o,
  // configuration write channel
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [dss_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [dss_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import dss_pkg::*;

  logic             policy_q;
  logic [CYL_W-1:0] start_head_q;

  // front-to-queue and queue-to-back transactions, the store write port and the batch-done signal
  logic      push_valid, push_ready, pop_valid, pop_ready;
  job_t      push_job, pop_job;
  store_wr_t store_wr;
  logic      batch_done;

  // the user must change registers only while the block is idle; the block does not check, and takes every write
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q     <= POLICY_FCFS;
      start_head_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_POLICY:     policy_q     <= cfg_data_i[0];
        REG_START_HEAD: start_head_q <= cfg_data_i[CYL_W-1:0];
        default:        ;
      endcase
    end
  end

  // front: stores requests, counts them, flags drops, closes the batch on last
  dss_front #(
    .MAX_REQUESTS(MAX_REQUESTS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .job_valid_o (push_valid),
    .job_ready_i (push_ready),
    .job_o       (push_job),
    .wr_o        (store_wr),
    .done_i      (batch_done)
  );

  // batch descriptors wait here until the back end is free
  dss_job_fifo #(
    .Depth(FIFO_DEPTH)
  ) u_job_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_job),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_job)
  );

  // back: scans the store for each result and drives the output register
  dss_back #(
    .MAX_REQUESTS(MAX_REQUESTS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .wr_i         (store_wr),
    .job_valid_i  (pop_valid),
    .job_ready_o  (pop_ready),
    .job_i        (pop_job),
    .policy_i     (policy_q),
    .start_head_i (start_head_q),
    .done_o       (batch_done),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_item_o   (out_item_o)
  );

endmodule
